@@ rtl/tcprc_pkg.sv @@
package tcprc_pkg;

  // bytes carried by one packet
  localparam int unsigned PACKET_BYTES = 1024;

  localparam int unsigned Q_W    = 32;
  localparam int unsigned ACK_W  = 32;
  localparam int unsigned XFER_W = 48;
  localparam int unsigned DUP_W  = 8;
  localparam int unsigned K_W    = 33;

  localparam logic [Q_W-1:0] ONE_Q        = 32'h0001_0000;
  localparam logic [Q_W-1:0] RESET_WINDOW = 32'h0004_0000;
  localparam logic [Q_W-1:0] RESET_THRESH = 32'h0040_0000;
  localparam logic [Q_W-1:0] MIN_THRESH   = 32'h0002_0000;
  localparam logic [Q_W-1:0] FR_FLOOR     = 32'h0004_0000;
  localparam logic [Q_W-1:0] FR_INFLATE   = 32'h0003_0000;
  localparam logic [DUP_W-1:0] DUP_TRIGGER = 8'd3;
  localparam logic [DUP_W-1:0] DUP_MAX     = 8'd255;

  typedef enum logic [1:0] {
    PH_SLOW_START    = 2'd0,
    PH_CONG_AVOID    = 2'd1,
    PH_FAST_RECOVERY = 2'd2
  } phase_t;

  // shared divider: numerator up to 3 packets of Q16.16, divisor up to 1.0
  localparam int unsigned DIV_NUM_W = 18;
  localparam int unsigned DIV_DEN_W = 17;
  localparam int unsigned DIV_STEPS = DIV_NUM_W;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/tcprc_div.sv @@
module tcprc_div import tcprc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CW-1:0]    cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_DEN_W:0]   partial;
  logic [DIV_DEN_W+1:0] diff;
  logic                 fits;

  // one restoring step per cycle, quotient bits shift in from the right
  assign partial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff    = {1'b0, partial} - {2'b00, den_r};
  assign fits    = !diff[DIV_DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      rem_r  <= '0;
      quo_r  <= req.num;
      den_r  <= req.den;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIV_DEN_W-1:0] : partial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ rtl/tcp_reno_congestion_window_top.sv @@
// Reno congestion window for one sender. Each input word is a cumulative ACK
// (in_tuser 0) or a retransmit timeout (in_tuser 1); each gives exactly one
// output word with the window, threshold, phase, base, retransmit request and
// done flag. A timeout, duplicate, stale or final ACK goes through S_EVAL and
// S_FIN, which loads the output register and raises out_tvalid. A new ACK
// covering k packets walks the window one phase segment at a time: a
// fast-recovery exit in S_STEP, a slow-start run through S_SS_ADD, and a
// congestion-avoidance segment (up to the next whole packet, or to the end of
// the ACK) through S_CA_RECIP to S_CA_ADD, with the shared 18-step divider
// forming the per-ACK increment and the step count to the next packet. in_tready
// is low while a word is being worked on; a finished word waits in the output
// register so the next input is taken as soon as the sequencer is free.
module tcp_reno_congestion_window_top import tcprc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [XFER_W-1:0] cfg_wr_data,   // transfer_bytes
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,      // ack_number[31:0]
  input  logic [0:0]        in_tuser,      // action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [87:0]       out_tdata      // window_packets[15:0], threshold_fixed[47:16],
                                           // phase[49:48], base_packet[81:50],
                                           // retransmit[82], done_res[83]
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_STEP, S_SS_ADD, S_CA_RECIP, S_CA_NEED, S_CA_MUL, S_CA_ADD, S_FIN
  } state_t;

  function automatic logic [Q_W-1:0] halve_floor2(input logic [Q_W-1:0] w);
    logic [Q_W-1:0] h;
    h = w >> 1;
    return (h < MIN_THRESH) ? MIN_THRESH : h;
  endfunction

  function automatic logic [Q_W-1:0] sat34(input logic [Q_W+1:0] s);
    return (s[Q_W+1:Q_W] != 2'b00) ? '1 : s[Q_W-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [Q_W-1:0]      w_r, w_nxt;
  logic [Q_W-1:0]      thr_r, thr_nxt;
  logic [DUP_W-1:0]    dup_r, dup_nxt;
  logic [ACK_W-1:0]    base_r, base_nxt;
  phase_t              phase_r, phase_nxt;
  logic                fin_r, fin_nxt;
  logic                rtx_r, rtx_nxt;
  logic [XFER_W-1:0]   xfer_r;
  logic                act_r, act_nxt;
  logic [ACK_W-1:0]    ack_r, ack_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [DIV_NUM_W-1:0] t_r, t_nxt;
  logic [DIV_DEN_W-1:0] d_r, d_nxt;
  logic [DIV_NUM_W+DIV_DEN_W-1:0] prod_r, prod_nxt;
  logic                ss_last_r, ss_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [87:0]         out_data_r, out_data_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [XFER_W:0]     ack_bytes;
  logic                final_hit;
  logic [DUP_W-1:0]    dup_inc;
  logic [Q_W-1:0]      thr_h;
  logic [16:0]         ss_need;
  logic [15:0]         n_eff;
  logic [15:0]         n_inc;
  logic [K_W-1:0]      need_num;
  logic [Q_W+1:0]      sum_w;

  tcprc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign ack_bytes = (XFER_W+1)'(ack_r) * (XFER_W+1)'(PACKET_BYTES);
  assign final_hit = ack_bytes >= {1'b0, xfer_r};
  assign dup_inc   = (dup_r == DUP_MAX) ? dup_r : dup_r + 1'b1;
  assign thr_h     = halve_floor2(w_r);

  // packets of slow start left before the threshold, rounded up
  always_comb begin
    logic [K_W-1:0] up;
    up = K_W'(thr_r - w_r) + K_W'(ONE_Q - 32'd1);
    ss_need = (w_r < thr_r) ? up[K_W-1:16] : 17'd1;
  end

  // a window below one packet counts as one for the reciprocal
  assign n_eff = (w_r[31:16] == 16'd0) ? 16'd1 : w_r[31:16];
  assign n_inc = n_eff + 16'd1;
  // steps needed to reach the next whole packet, rounded up
  assign need_num = {1'b0, n_inc, 16'h0000} - {1'b0, w_r}
                  + K_W'(div_rsp.quo[DIV_DEN_W-1:0]) - K_W'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    thr_nxt       = thr_r;
    dup_nxt       = dup_r;
    base_nxt      = base_r;
    phase_nxt     = phase_r;
    fin_nxt       = fin_r;
    rtx_nxt       = rtx_r;
    act_nxt       = act_r;
    ack_nxt       = ack_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    ss_last_nxt   = ss_last_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    div_req       = '0;
    sum_w         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tuser[0];
          ack_nxt   = in_tdata;
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        rtx_nxt   = 1'b0;
        state_nxt = S_FIN;
        if (fin_r) begin
          // transfer complete, state is frozen
        end else if (act_r) begin
          thr_nxt   = thr_h;
          w_nxt     = ONE_Q;
          dup_nxt   = '0;
          phase_nxt = PH_SLOW_START;
          rtx_nxt   = 1'b1;
        end else if (final_hit) begin
          fin_nxt = 1'b1;
        end else if (ack_r >= base_r) begin
          k_nxt     = K_W'(ack_r - base_r) + K_W'(1);
          dup_nxt   = '0;
          base_nxt  = ack_r + 32'd1;
          state_nxt = S_STEP;
        end else if (ack_r == base_r - 32'd1) begin
          dup_nxt = dup_inc;
          if (phase_r == PH_FAST_RECOVERY) begin
            w_nxt = sat34((Q_W+2)'(w_r) + (Q_W+2)'(ONE_Q));
          end else if (dup_inc == DUP_TRIGGER) begin
            thr_nxt   = thr_h;
            w_nxt     = sat34((Q_W+2)'(thr_h) + (Q_W+2)'(FR_INFLATE));
            phase_nxt = PH_FAST_RECOVERY;
            rtx_nxt   = 1'b1;
          end
        end
      end

      S_STEP: begin
        if (k_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          unique case (phase_r)
            PH_FAST_RECOVERY: begin
              w_nxt     = (thr_r < FR_FLOOR) ? FR_FLOOR : thr_r;
              phase_nxt = PH_CONG_AVOID;
              k_nxt     = k_r - K_W'(1);
            end
            PH_SLOW_START: begin
              if (k_r < K_W'(ss_need)) begin
                t_nxt       = k_r[DIV_NUM_W-1:0];
                ss_last_nxt = 1'b0;
              end else begin
                t_nxt       = DIV_NUM_W'(ss_need);
                ss_last_nxt = 1'b1;
              end
              state_nxt = S_SS_ADD;
            end
            PH_CONG_AVOID: begin
              if (n_eff == 16'hFFFF) begin
                // increment is exactly one lsb here
                w_nxt = sat34((Q_W+2)'(w_r) + (Q_W+2)'(k_r));
                k_nxt = '0;
              end else begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(ONE_Q);
                div_req.den   = DIV_DEN_W'(n_eff);
                state_nxt     = S_CA_RECIP;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_SS_ADD: begin
        sum_w = (Q_W+2)'(w_r) + (Q_W+2)'({t_r, 16'h0000});
        w_nxt = sat34(sum_w);
        k_nxt = k_r - K_W'(t_r);
        if (ss_last_r || sat34(sum_w) >= thr_r) begin
          phase_nxt = PH_CONG_AVOID;
        end
        state_nxt = S_STEP;
      end

      S_CA_RECIP: begin
        if (div_rsp.done) begin
          d_nxt         = div_rsp.quo[DIV_DEN_W-1:0];
          div_req.start = 1'b1;
          div_req.num   = need_num[DIV_NUM_W-1:0];
          div_req.den   = div_rsp.quo[DIV_DEN_W-1:0];
          state_nxt     = S_CA_NEED;
        end
      end

      S_CA_NEED: begin
        if (div_rsp.done) begin
          t_nxt     = (k_r < K_W'(div_rsp.quo)) ? k_r[DIV_NUM_W-1:0] : div_rsp.quo;
          state_nxt = S_CA_MUL;
        end
      end

      S_CA_MUL: begin
        prod_nxt  = (DIV_NUM_W+DIV_DEN_W)'(t_r) * (DIV_NUM_W+DIV_DEN_W)'(d_r);
        state_nxt = S_CA_ADD;
      end

      S_CA_ADD: begin
        sum_w     = (Q_W+2)'(w_r) + (Q_W+2)'(prod_r);
        w_nxt     = sat34(sum_w);
        k_nxt     = k_r - K_W'(t_r);
        state_nxt = S_STEP;
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {4'b0000, fin_r, rtx_r, base_r, phase_r, thr_r, w_r[31:16]};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_r         <= RESET_WINDOW;
      thr_r       <= RESET_THRESH;
      dup_r       <= '0;
      base_r      <= 32'd1;
      phase_r     <= PH_SLOW_START;
      fin_r       <= 1'b0;
      rtx_r       <= 1'b0;
      out_valid_r <= 1'b0;
      xfer_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      thr_r       <= thr_nxt;
      dup_r       <= dup_nxt;
      base_r      <= base_nxt;
      phase_r     <= phase_nxt;
      fin_r       <= fin_nxt;
      rtx_r       <= rtx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        xfer_r <= cfg_wr_data;
      end
    end
    act_r      <= act_nxt;
    ack_r      <= ack_nxt;
    k_r        <= k_nxt;
    t_r        <= t_nxt;
    d_r        <= d_nxt;
    prod_r     <= prod_nxt;
    ss_last_r  <= ss_last_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is in progress");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> fin_r)
    else $error("finished flag dropped");

  a_thresh_floor: assert property (@(posedge clk) disable iff (!rst_n)
    thr_r >= MIN_THRESH)
    else $error("threshold below two packets");

  a_window_floor: assert property (@(posedge clk) disable iff (!rst_n)
    w_r >= ONE_Q)
    else $error("window below one packet");
`endif

endmodule

@@ sim/tcp_reno_congestion_window_top_tb.sv @@
`timescale 1ns / 100ps

module tcp_reno_congestion_window_top_tb;
  import tcprc_pkg::*;

  localparam logic EV_ACK     = 1'b0;
  localparam logic EV_TIMEOUT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] ack;
  } ack_event_t;

  typedef struct packed {
    logic [15:0] win_pkts;
    logic [31:0] thr;
    phase_t      ph;
    logic [31:0] base;
    logic        rtx;
    logic        done;
  } cwnd_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [XFER_W-1:0] cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;    // ack_number[31:0]
  logic [0:0]        in_tuser = '0;    // action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [87:0]       out_tdata;        // window_packets[15:0], threshold_fixed[47:16],
                                       // phase[49:48], base_packet[81:50],
                                       // retransmit[82], done_res[83]

  // predicted controller state
  logic [31:0]       cw_win = RESET_WINDOW;
  logic [31:0]       cw_thr = RESET_THRESH;
  logic [DUP_W-1:0]  dup_cnt = '0;
  logic [31:0]       cw_base = 32'd1;
  phase_t            cw_phase = PH_SLOW_START;
  logic              cw_done = 1'b0;
  logic [XFER_W-1:0] xfer_bytes = '0;

  // stimulus side: tracks the window base so new acks stay small
  logic [31:0]       gen_base = 32'd1;
  logic              gen_done = 1'b0;
  logic              flood_pending = 1'b1;
  int                queued_events = 0;

  ack_event_t        pending_events[$];
  cwnd_result_t      expected_results[$];
  int                mismatches = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                stall_req = 0;
  int                stall_seen = 0;
  int                hold_left = 0;

  tcp_reno_congestion_window_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] sat_q(input longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] half_window(input logic [31:0] w);
    logic [31:0] h;
    h = w >> 1;
    return (h < MIN_THRESH) ? MIN_THRESH : h;
  endfunction

  function automatic cwnd_result_t predict_event(input logic act, input logic [31:0] ack);
    cwnd_result_t r;
    logic rtx;
    longint unsigned k, w, lim, need, t, n, d, goal, bytes;
    rtx = 1'b0;
    bytes = ack;
    bytes = bytes * PACKET_BYTES;
    if (!cw_done) begin
      if (act == EV_TIMEOUT) begin
        cw_thr = half_window(cw_win);
        cw_win = ONE_Q;
        dup_cnt = '0;
        cw_phase = PH_SLOW_START;
        rtx = 1'b1;
      end else if (bytes >= xfer_bytes) begin
        cw_done = 1'b1;
      end else if (ack >= cw_base) begin
        k = ack;
        n = cw_base;
        k = k - n + 1;
        dup_cnt = '0;
        // one phase segment per pass
        while (k != 0) begin
          w = cw_win;
          lim = cw_thr;
          case (cw_phase)
            PH_FAST_RECOVERY: begin
              cw_win = (cw_thr < FR_FLOOR) ? FR_FLOOR : cw_thr;
              cw_phase = PH_CONG_AVOID;
              k = k - 1;
            end
            PH_SLOW_START: begin
              need = 1;
              if (w < lim) need = (lim - w + ONE_Q - 1) / ONE_Q;
              t = (k < need) ? k : need;
              cw_win = sat_q(w + t * ONE_Q);
              k = k - t;
              if (t == need || cw_win >= cw_thr) cw_phase = PH_CONG_AVOID;
            end
            default: begin
              n = w >> 16;
              if (n == 0) n = 1;
              d = ONE_Q / n;
              if (n >= 65535) begin
                cw_win = sat_q(w + k * d);
                k = 0;
              end else begin
                // steps until the whole part of the window moves up
                goal = (n + 1) << 16;
                need = (goal > w) ? (goal - w + d - 1) / d : 1;
                t = (k < need) ? k : need;
                cw_win = sat_q(w + t * d);
                k = k - t;
              end
            end
          endcase
        end
        cw_base = ack + 32'd1;
      end else if (ack == cw_base - 32'd1) begin
        if (dup_cnt < DUP_MAX) dup_cnt = dup_cnt + 1'b1;
        w = cw_win;
        if (cw_phase == PH_FAST_RECOVERY) cw_win = sat_q(w + ONE_Q);
        if (dup_cnt == DUP_TRIGGER && cw_phase != PH_FAST_RECOVERY) begin
          cw_thr = half_window(cw_win);
          w = cw_thr;
          cw_win = sat_q(w + FR_INFLATE);
          cw_phase = PH_FAST_RECOVERY;
          rtx = 1'b1;
        end
      end
    end
    r.win_pkts = cw_win[31:16];
    r.thr = cw_thr;
    r.ph = cw_phase;
    r.base = cw_base;
    r.rtx = rtx;
    r.done = cw_done;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_event(input logic act, input logic [31:0] ack);
    ack_event_t ev;
    longint unsigned bytes;
    ev.action = act;
    ev.ack = ack;
    pending_events.push_back(ev);
    queued_events++;
    bytes = ack;
    bytes = bytes * PACKET_BYTES;
    if (act == EV_ACK && !gen_done) begin
      if (bytes >= xfer_bytes) gen_done = 1'b1;
      else if (ack >= gen_base) gen_base = ack + 32'd1;
    end
  endtask

  task automatic write_transfer(input logic [XFER_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    xfer_bytes = v;
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic gen_random(input int n_events);
    int stop_at, r, pick;
    logic [31:0] k;
    stop_at = queued_events + n_events;
    while (queued_events < stop_at) begin
      r = $urandom_range(99);
      if (flood_pending && queued_events > stop_at - n_events / 2) begin
        // long duplicate run drives the duplicate count into saturation
        flood_pending = 1'b0;
        repeat (260) queue_event(EV_ACK, gen_base - 32'd1);
      end else if (r < 45) begin
        pick = $urandom_range(99);
        if (pick < 70) k = $urandom_range(8, 1);
        else if (pick < 95) k = $urandom_range(64, 9);
        else k = $urandom_range(400, 65);
        queue_event(EV_ACK, gen_base - 32'd1 + k);
      end else if (r < 62) begin
        repeat ($urandom_range(5, 1)) queue_event(EV_ACK, gen_base - 32'd1);
        if ($urandom_range(1)) queue_event(EV_ACK, gen_base + $urandom_range(3));
      end else if (r < 72) begin
        queue_event(EV_TIMEOUT, $urandom);
      end else if (r < 84 && gen_base >= 2) begin
        queue_event(EV_ACK, $urandom_range(gen_base - 2));
      end else begin
        queue_event(EV_ACK, $urandom_range(gen_base + 3));
      end
    end
  endtask

  // input side: predict each accepted word, then offer the next one
  always @(posedge clk) begin : drive_proc
    ack_event_t ev;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(predict_event(in_tuser[0], in_tdata));
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= ev.action;
          in_tdata <= ev.ack;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      hold_left <= 300;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_proc
    cwnd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no outstanding event");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("window_packets", want.win_pkts, out_tdata[15:0]);
        check_field("threshold_fixed", want.thr, out_tdata[47:16]);
        check_field("phase", want.ph, out_tdata[49:48]);
        check_field("base_packet", want.base, out_tdata[81:50]);
        check_field("retransmit", want.rtx, out_tdata[82]);
        check_field("done_res", want.done, out_tdata[83]);
      end
    end
  end

  initial begin
    logic [31:0] b;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 54;
    // largest transfer: no ack can finish it
    write_transfer('1);

    // three duplicates into fast recovery, inflate, timeout out of recovery
    repeat (3) queue_event(EV_ACK, 32'd0);
    queue_event(EV_ACK, 32'd0);
    queue_event(EV_TIMEOUT, 32'hFFFF_FFFF);
    queue_event(EV_ACK, 32'd0);
    // slow start partly, then across the threshold into avoidance
    queue_event(EV_ACK, 32'd1);
    queue_event(EV_ACK, 32'd6);
    queue_event(EV_ACK, 32'd0);
    repeat (3) queue_event(EV_ACK, gen_base - 32'd1);
    queue_event(EV_ACK, gen_base + 32'd33);
    queue_event(EV_ACK, gen_base - 32'd1);
    queue_event(EV_TIMEOUT, 32'd0);
    queue_event(EV_ACK, gen_base + 32'd200);
    queue_event(EV_TIMEOUT, 32'h5555_5555);
    queue_event(EV_TIMEOUT, 32'hAAAA_AAAA);
    queue_event(EV_ACK, gen_base + 32'd2);
    gen_random(300);
    drain();

    send_idle_pct = 54;
    recv_idle_pct = 17;
    write_transfer((gen_base + 48'd100000) * PACKET_BYTES + $urandom_range(1023));
    gen_random(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_transfer((gen_base + 48'd200000) * PACKET_BYTES);
    stall_req = stall_req + 1;
    gen_random(300);
    drain();

    // zero transfer: timeouts still act normally
    write_transfer('0);
    repeat (3) queue_event(EV_TIMEOUT, $urandom);
    drain();

    // boundary: one ack just short of the transfer, then the finishing one
    b = gen_base;
    write_transfer((b + 48'd3) * PACKET_BYTES - 1);
    queue_event(EV_ACK, b + 32'd2);
    queue_event(EV_ACK, b + 32'd3);
    queue_event(EV_TIMEOUT, $urandom);
    queue_event(EV_ACK, 32'hFFFF_FFFF);
    queue_event(EV_ACK, 32'd0);
    drain();
    write_transfer('1);
    queue_event(EV_ACK, gen_base + 32'd5);
    queue_event(EV_TIMEOUT, $urandom);
    drain();

    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
